@@ hdl/tws_pkg.sv @@
package tws_pkg;

  localparam int unsigned MaxWindows = 16;
  localparam int unsigned IdxW       = 4;
  localparam int unsigned CntW       = 5;
  localparam int unsigned SampleW    = 24;
  localparam int unsigned SumW       = 28;
  localparam int unsigned SxxW       = 63;
  localparam int unsigned TimeW      = 32;

  typedef enum logic [1:0] {
    StAccepted = 2'd0,
    StStale    = 2'd1,
    StResetDone = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    FsmIdle,
    FsmRead,
    FsmDiv,
    FsmCalc,
    FsmWrite,
    FsmEmitRd,
    FsmEmit,
    FsmSingle
  } fsm_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic            load;      // capture sample
    logic            div_start; // begin dx / (idx+2)
    logic            calc;      // form new mean, sum, product
    logic            wr;        // write window idx+1 from computed values
    logic            wr_first;  // write window 0 from sample
    logic [IdxW-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_sts_t;

  // Signed divide result widths: dx fits 26 bits.
  localparam int unsigned DxW = 26;

endpackage

@@ hdl/tws_ram.sv @@
module tws_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ hdl/tws_datapath.sv @@
module tws_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tws_pkg::dp_cmd_t                    cmd_i,
  output tws_pkg::dp_sts_t                    sts_o,
  input  logic signed [tws_pkg::SampleW-1:0]  sample_i,
  output logic signed [tws_pkg::SumW-1:0]     sum_o,
  output logic signed [tws_pkg::SampleW-1:0]  mean_o,
  output logic [tws_pkg::SxxW-1:0]            sxx_o
);
  localparam int unsigned DxW  = tws_pkg::DxW;
  localparam int unsigned QW   = DxW;
  localparam logic [tws_pkg::SxxW-1:0] SxxMax = '1;

  logic signed [tws_pkg::SampleW-1:0] x_q;
  logic signed [tws_pkg::SumW-1:0]    rd_sum;
  logic signed [tws_pkg::SampleW-1:0] rd_mean;
  logic [tws_pkg::SxxW-1:0]           rd_sxx;

  logic signed [tws_pkg::SumW-1:0]    wsum;
  logic signed [tws_pkg::SampleW-1:0] wmean;
  logic [tws_pkg::SxxW-1:0]           wsxx;
  logic [tws_pkg::IdxW-1:0]           waddr;
  logic                               we;

  // Restoring divider state
  logic [DxW-1:0]  num_q;
  logic [5:0]      den_q;
  logic [DxW:0]    rem_q;
  logic [QW-1:0]   quo_q;
  logic            neg_q;
  logic [4:0]      cnt_q;
  logic            busy_q;
  logic signed [DxW-1:0] dx_q;

  logic signed [DxW-1:0]  dx;
  logic [DxW:0]           rem_sh;
  logic signed [DxW+1:0]  step;
  logic signed [DxW+1:0]  mraw;
  logic signed [tws_pkg::SampleW-1:0] m_new;
  logic signed [DxW+1:0]  xm;
  logic signed [2*DxW+1:0] prod_n;
  logic signed [2*DxW+3:0] prod;
  logic signed [tws_pkg::SumW:0] sraw;

  logic signed [tws_pkg::SampleW-1:0] m_q;
  logic signed [tws_pkg::SumW-1:0]    s_q;
  logic signed [2*DxW+3:0]            prod_q;
  logic [tws_pkg::SxxW:0]             sxx_add;
  logic [tws_pkg::SxxW-1:0]           sxx_next;
  logic [2*DxW+3:0]                   mag;

  tws_ram #(.Width(tws_pkg::SumW), .Depth(tws_pkg::MaxWindows)) u_sum (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wsum),
    .raddr_i(cmd_i.idx), .rdata_o(rd_sum));
  tws_ram #(.Width(tws_pkg::SampleW), .Depth(tws_pkg::MaxWindows)) u_mean (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wmean),
    .raddr_i(cmd_i.idx), .rdata_o(rd_mean));
  tws_ram #(.Width(tws_pkg::SxxW), .Depth(tws_pkg::MaxWindows)) u_sxx (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wsxx),
    .raddr_i(cmd_i.idx), .rdata_o(rd_sxx));

  assign sum_o  = rd_sum;
  assign mean_o = rd_mean;
  assign sxx_o  = rd_sxx;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q <= sample_i;
    end
  end

  assign dx = DxW'(x_q) - DxW'(rd_mean);
  assign rem_sh = {rem_q[DxW-1:0], num_q[DxW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (cmd_i.div_start) begin
      busy_q <= 1'b1;
      cnt_q  <= 5'(DxW - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dx_q  <= dx;
      neg_q <= dx[DxW-1];
      num_q <= dx[DxW-1] ? DxW'(-dx) : DxW'(dx);
      den_q <= 6'({1'b0, cmd_i.idx} + 5'd2);
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[DxW-2:0], 1'b0};
      if (rem_sh >= (DxW+1)'(den_q)) begin
        rem_q <= rem_sh - (DxW+1)'(den_q);
        quo_q <= {quo_q[QW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[QW-2:0], 1'b0};
      end
    end
  end

  assign sts_o.div_done = !busy_q;

  always_comb begin
    step = neg_q ? -(DxW+2)'($signed({1'b0, quo_q})) : (DxW+2)'($signed({1'b0, quo_q}));
    mraw = (DxW+2)'(rd_mean) + step;
    if (mraw > (DxW+2)'(24'sh7FFFFF)) begin
      m_new = 24'sh7FFFFF;
    end else if (mraw < -(DxW+2)'(24'sh7FFFFF) - (DxW+2)'(1)) begin
      m_new = 24'sh800000;
    end else begin
      m_new = mraw[tws_pkg::SampleW-1:0];
    end
    xm     = (DxW+2)'(x_q) - (DxW+2)'(m_new);
    // 26 x 28 signed product; both operands stay within 25 bits of magnitude.
    prod_n = dx_q * xm;
    prod   = (2*DxW+4)'(prod_n);
    sraw   = (tws_pkg::SumW+1)'(rd_sum) + (tws_pkg::SumW+1)'(x_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      m_q    <= m_new;
      prod_q <= prod;
      if (sraw > (tws_pkg::SumW+1)'(28'sh7FFFFFF)) begin
        s_q <= 28'sh7FFFFFF;
      end else if (sraw < -(tws_pkg::SumW+1)'(28'sh7FFFFFF) - (tws_pkg::SumW+1)'(1)) begin
        s_q <= 28'sh8000000;
      end else begin
        s_q <= sraw[tws_pkg::SumW-1:0];
      end
    end
  end

  always_comb begin
    mag     = prod_q[2*DxW+3] ? (2*DxW+4)'(-prod_q) : prod_q;
    sxx_add = {1'b0, rd_sxx} + (tws_pkg::SxxW+1)'(mag);
    if (!prod_q[2*DxW+3]) begin
      sxx_next = sxx_add[tws_pkg::SxxW] ? SxxMax : sxx_add[tws_pkg::SxxW-1:0];
    end else begin
      sxx_next = (rd_sxx > tws_pkg::SxxW'(mag)) ? rd_sxx - tws_pkg::SxxW'(mag) : '0;
    end
  end

  always_comb begin
    we    = cmd_i.wr | cmd_i.wr_first;
    waddr = cmd_i.wr_first ? '0 : cmd_i.idx + tws_pkg::IdxW'(1);
    wsum  = cmd_i.wr_first ? tws_pkg::SumW'(x_q) : s_q;
    wmean = cmd_i.wr_first ? x_q : m_q;
    wsxx  = cmd_i.wr_first ? '0 : sxx_next;
  end
endmodule

@@ hdl/tws_ctrl.sv @@
module tws_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [tws_pkg::CntW-1:0]      window_count_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          mode_i,
  input  logic [tws_pkg::TimeW-1:0]     timestamp_i,
  output tws_pkg::dp_cmd_t              cmd_o,
  input  tws_pkg::dp_sts_t              sts_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output tws_pkg::status_e              status_o,
  output logic [tws_pkg::IdxW-1:0]      idx_o,
  output logic                          gap_o,
  output logic                          last_o,
  output logic                          data_zero_o
);
  tws_pkg::fsm_e state_q, state_d;
  logic [tws_pkg::IdxW-1:0] idx_q, idx_d, n1_q, n1_d;
  logic [tws_pkg::TimeW-1:0] last_time_q, last_time_d;
  logic time_valid_q, time_valid_d;
  logic gap_q, gap_d;
  tws_pkg::status_e st_q, st_d;
  logic [tws_pkg::IdxW-1:0] ncap;
  logic accept;

  always_comb begin
    if (window_count_i == '0) begin
      ncap = '0;
    end else if (window_count_i > tws_pkg::CntW'(tws_pkg::MaxWindows)) begin
      ncap = tws_pkg::IdxW'(tws_pkg::MaxWindows - 1);
    end else begin
      ncap = tws_pkg::IdxW'(window_count_i - tws_pkg::CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= tws_pkg::FsmIdle;
      idx_q        <= '0;
      n1_q         <= '0;
      last_time_q  <= '0;
      time_valid_q <= 1'b0;
      gap_q        <= 1'b0;
      st_q         <= tws_pkg::StAccepted;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      n1_q         <= n1_d;
      last_time_q  <= last_time_d;
      time_valid_q <= time_valid_d;
      gap_q        <= gap_d;
      st_q         <= st_d;
    end
  end

  assign in_ready_o = (state_q == tws_pkg::FsmIdle);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    n1_d         = n1_q;
    last_time_d  = last_time_q;
    time_valid_d = time_valid_q;
    gap_d        = gap_q;
    st_d         = st_q;
    cmd_o        = '0;
    cmd_o.idx    = idx_q;
    out_valid_o  = 1'b0;
    case (state_q)
      tws_pkg::FsmIdle: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          if (mode_i) begin
            time_valid_d = 1'b0;
            last_time_d  = '0;
            st_d         = tws_pkg::StResetDone;
            state_d      = tws_pkg::FsmSingle;
          end else if (time_valid_q && timestamp_i <= last_time_q) begin
            st_d    = tws_pkg::StStale;
            state_d = tws_pkg::FsmSingle;
          end else begin
            gap_d = time_valid_q ? (timestamp_i != last_time_q + 32'd1)
                                 : (timestamp_i != '0);
            last_time_d  = timestamp_i;
            time_valid_d = 1'b1;
            st_d         = tws_pkg::StAccepted;
            n1_d         = ncap;
            if (ncap == '0) begin
              idx_d   = '0;
              state_d = tws_pkg::FsmWrite;
            end else begin
              // Walk windows downward so each reads the older neighbor.
              idx_d   = ncap - tws_pkg::IdxW'(1);
              state_d = tws_pkg::FsmRead;
            end
          end
        end
      end
      tws_pkg::FsmRead: begin
        cmd_o.div_start = 1'b0;
        state_d = tws_pkg::FsmDiv;
      end
      tws_pkg::FsmDiv: begin
        cmd_o.div_start = 1'b1;
        state_d = tws_pkg::FsmCalc;
      end
      tws_pkg::FsmCalc: begin
        if (sts_i.div_done) begin
          cmd_o.calc = 1'b1;
          state_d    = tws_pkg::FsmWrite;
        end
      end
      tws_pkg::FsmWrite: begin
        if (n1_q == '0 || idx_q == '1) begin
          cmd_o.wr_first = 1'b1;
          idx_d   = '0;
          state_d = tws_pkg::FsmEmitRd;
        end else begin
          cmd_o.wr = 1'b1;
          if (idx_q == '0) begin
            idx_d   = '1;
            state_d = tws_pkg::FsmWrite;
          end else begin
            idx_d   = idx_q - tws_pkg::IdxW'(1);
            state_d = tws_pkg::FsmRead;
          end
        end
      end
      tws_pkg::FsmEmitRd: begin
        state_d = tws_pkg::FsmEmit;
      end
      tws_pkg::FsmEmit: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (idx_q == n1_q) begin
            state_d = tws_pkg::FsmIdle;
          end else begin
            idx_d     = idx_q + tws_pkg::IdxW'(1);
            cmd_o.idx = idx_d;
            state_d   = tws_pkg::FsmEmit;
          end
        end
      end
      tws_pkg::FsmSingle: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = tws_pkg::FsmIdle;
        end
      end
      default: state_d = tws_pkg::FsmIdle;
    endcase
  end

  assign status_o    = st_q;
  assign data_zero_o = (state_q == tws_pkg::FsmSingle);
  assign idx_o       = data_zero_o ? '0 : idx_q;
  assign gap_o       = data_zero_o ? 1'b0 : gap_q;
  assign last_o      = data_zero_o || (idx_q == n1_q);
endmodule

@@ hdl/trailing_window_statistics_top.sv @@
// Trailing window statistics (running Welford variance per window length).
// Channels: s_axis carries one request per sample: tuser = mode,
//   tdata = {sample[23:0], timestamp[31:0]}. m_axis returns results:
//   tdata = {sxx, mean, sum, window_index, status}, tuser = time_gap,
//   tlast marks the final result of a request. cfg writes window_count.
// A sample request with n windows yields n results, window index 0 first.
// Each window update runs read, divider start, 26 divide steps, a compute
//   step and a write, walked from the longest window down; the first result
//   follows the last update, then one result per cycle while m_axis_tready
//   is high.
// A stale or reset-mode request yields one result in the cycle after accept.
// Throughput: one request at a time; s_axis_tready is high only when idle.
// Reset clears the time tracking and sets window_count to 16; the window
//   stores are not cleared and read undefined until first written.
// A receiver stall holds the current result on m_axis; no result drops.
module trailing_window_statistics_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [4:0]   cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,   // timestamp[31:0], sample[55:32]
  input  logic         s_axis_tuser,   // mode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // status[1:0], window_index[5:2],
                                       // window_sum[33:6], window_mean[57:34],
                                       // window_sxx[120:58]
  output logic         m_axis_tuser,   // time_gap
  output logic         m_axis_tlast
);
  logic [tws_pkg::CntW-1:0] window_count_q;
  tws_pkg::dp_cmd_t cmd;
  tws_pkg::dp_sts_t sts;
  tws_pkg::status_e status;
  logic [tws_pkg::IdxW-1:0] idx;
  logic gap, zero;
  logic signed [tws_pkg::SumW-1:0] sum;
  logic signed [tws_pkg::SampleW-1:0] mean;
  logic [tws_pkg::SxxW-1:0] sxx;

  // Take configuration whenever offered; the user must write it only while idle, as the block does not enforce it.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_count_q <= tws_pkg::CntW'(tws_pkg::MaxWindows);
    end else if (cfg_valid_i) begin
      window_count_q <= cfg_data_i;
    end
  end

  tws_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .window_count_i(window_count_q),
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .mode_i(s_axis_tuser), .timestamp_i(s_axis_tdata[31:0]),
    .cmd_o(cmd), .sts_i(sts),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .status_o(status), .idx_o(idx), .gap_o(gap), .last_o(m_axis_tlast),
    .data_zero_o(zero));

  tws_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .sample_i(s_axis_tdata[55:32]),
    .sum_o(sum), .mean_o(mean), .sxx_o(sxx));

  // Blank the payload for single status results.
  assign m_axis_tdata = {7'b0,
                         zero ? 63'b0 : sxx,
                         zero ? 24'b0 : mean,
                         zero ? 28'b0 : sum,
                         idx, status};
  assign m_axis_tuser = gap;

`ifndef SYNTHESIS
  a_tready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tready |-> !m_axis_tvalid)) else $error("accept while emitting");
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && status != tws_pkg::StAccepted |-> m_axis_tlast))
    else $error("status result not last");
  a_gap_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && status == tws_pkg::StStale |-> !m_axis_tuser && idx == '0))
    else $error("stale result carries data");
`endif
endmodule
